### rtl/adaptive_golomb_sample_coder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive Golomb sample coder
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_GOLOMB_SAMPLE_CODER_TOP_ASSERT_SVH
`define ADAPTIVE_GOLOMB_SAMPLE_CODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// check that is skipped while reset is asserted
`define AGSC_ASSERT_RST(name, clock, resetn, prop) \
  name: assert property (@(posedge clock) disable iff (!resetn) prop) \
    else $error("agsc check failed");

// check that also runs while reset is asserted
`define AGSC_ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("agsc check failed");

`else

`define AGSC_ASSERT_RST(name, clock, resetn, prop)
`define AGSC_ASSERT_ALWAYS(name, clock, prop)

`endif

`endif

### rtl/agsc_pkg.sv
// ----------------------------------------------------------------------------
// agsc_pkg
// Widths, register indexes and reset values for the adaptive Golomb coder.
// ----------------------------------------------------------------------------
package agsc_pkg;

  // item field widths
  localparam int BAND_W = 8;
  localparam int RES_W  = 16;
  localparam int LEN_W  = 6;

  // configuration register widths
  localparam int UMAX_W = 6;
  localparam int DR_W   = 5;
  localparam int CSZ_W  = 4;
  localparam int CNT_W  = 11;
  localparam int ACC_W  = 27;

  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UMAX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DYN_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACC  = 3'd4;

  // reset values
  localparam logic [UMAX_W-1:0] UMAX_RST     = 6'd18;
  localparam logic [DR_W-1:0]   DR_RST       = 5'd16;
  localparam logic [CSZ_W-1:0]  CSZ_RST      = 4'd8;
  localparam logic [CNT_W-1:0]  INIT_CNT_RST = 11'd2;
  localparam logic [ACC_W-1:0]  INIT_ACC_RST = 27'd95;

  // saturation limits of the registers
  localparam logic [UMAX_W-1:0] UMAX_MAX = 6'd32;
  localparam logic [DR_W-1:0]   DR_MIN   = 5'd2;
  localparam logic [DR_W-1:0]   DR_MAX   = 5'd16;
  localparam logic [CSZ_W-1:0]  CSZ_MIN  = 4'd4;
  localparam logic [CSZ_W-1:0]  CSZ_MAX  = 4'd11;

  // k search and accumulator arithmetic
  localparam int K_W    = 4;
  localparam int K_MAX  = RES_W - 2;
  localparam int SUM_W  = ACC_W + 1;
  localparam int PROD_W = CNT_W + 6;
  localparam int MUL_49 = 49;
  localparam int FRAC_SHIFT = 7;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // longest codeword: saturated umax plus full depth
  localparam int CODE_LEN_MAX = 48;

  // band memory
  localparam int BAND_COUNT_DEF = 256;
  localparam int BAND_LUT_DEPTH = 1 << BAND_W;
  localparam int STATE_W = CNT_W + ACC_W;

endpackage

### rtl/agsc_in_if.sv
// ----------------------------------------------------------------------------
// agsc_in_if
// Sample item channel: band, first-in-band flag and mapped residual.
// ----------------------------------------------------------------------------
interface agsc_in_if
  import agsc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BAND_W-1:0] band;
  logic              first_in_band;
  logic [RES_W-1:0]  mapped_residual;

  modport source (output valid, output band, output first_in_band,
                  output mapped_residual, input ready);
  modport sink   (input valid, input band, input first_in_band,
                  input mapped_residual, output ready);
endinterface

### rtl/agsc_out_if.sv
// ----------------------------------------------------------------------------
// agsc_out_if
// Codeword item channel: right-aligned code value and total length.
// ----------------------------------------------------------------------------
interface agsc_out_if
  import agsc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] code_value;
  logic [LEN_W-1:0] code_length;

  modport source (output valid, output code_value, output code_length,
                  input ready);
  modport sink   (input valid, input code_value, input code_length,
                  output ready);
endinterface

### rtl/agsc_ram.sv
// ----------------------------------------------------------------------------
// agsc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module agsc_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/adaptive_golomb_sample_coder_top.sv
// ----------------------------------------------------------------------------
// adaptive_golomb_sample_coder_top
// Sample-adaptive Golomb-power-of-two coder with per-band statistics.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one sample item (band, first-in-band flag, mapped
//   residual); out_chan returns one codeword item (value, length) per sample.
//   Both use valid/ready. The cfg_ port writes one register per cycle; the
//   user must write only while the block is idle, the block does not enforce it.
//   A first-in-band sample writes the band's counter and accumulator and
//   returns the raw sample: it goes from S_IDLE through S_OUT to the output register.
//   Any other sample reads the band memory at acceptance, forms the k bound
//   (S_LOAD), searches k with one shift-and-compare unit, one step per
//   cycle (S_SEARCH, k <= D-2), codes and writes back (S_CODE) and loads the
//   output register (S_OUT). A new sample is accepted only in S_IDLE, once the
//   previous one has left S_OUT, so the k search sets the sample rate.
//   The codeword sits in an output register, so the next item is accepted
//   while a result waits; a stalled receiver holds the block in its final
//   step until the output register frees up.
//   Reset restores the register defaults and empties the pipeline; the band
//   memory is not cleared, each band is set up by its first-in-band sample.
// ----------------------------------------------------------------------------
`include "adaptive_golomb_sample_coder_top_assert.svh"

module adaptive_golomb_sample_coder_top
  import agsc_pkg::*;
#(
  parameter int BAND_COUNT = BAND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  agsc_in_if.sink               in_chan,
  agsc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BAND_AW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_CODE   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  // configuration registers
  logic [UMAX_W-1:0] umax_r;
  logic [DR_W-1:0]   dyn_range_r;
  logic [CSZ_W-1:0]  rescale_bits_r;
  logic [CNT_W-1:0]  init_cnt_r;
  logic [ACC_W-1:0]  init_acc_r;

  // sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic [BAND_AW-1:0] band_r;
  logic [RES_W-1:0]   m_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic [SUM_W-1:0]   sum_r;
  logic [K_W-1:0]     k_r;
  logic [RES_W-1:0]   res_value_r;
  logic [LEN_W-1:0]   res_length_r;
  logic               out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]   out_value_r;
  logic [LEN_W-1:0]   out_length_r;

  // saturated settings
  logic [DR_W-1:0]   d_sat;
  logic [UMAX_W-1:0] um_sat;
  logic [CSZ_W-1:0]  csz_sat;
  logic [K_W-1:0]    k_limit;
  logic [RES_W-1:0]  dmask;
  logic [CNT_W-1:0]  cnt_limit;

  // input side
  logic               accept;
  logic [BAND_AW-1:0] band_lut [BAND_LUT_DEPTH];
  logic [BAND_AW-1:0] band_sel;
  logic [RES_W-1:0]   m_in;

  // band memory
  logic               ram_we;
  logic [BAND_AW-1:0] ram_waddr;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]   rd_cnt;
  logic [ACC_W-1:0]   rd_acc;

  // arithmetic
  logic [PROD_W-1:0] prod49;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  cnt_shift;
  logic              step_ok;
  logic [RES_W-1:0]  u_val;
  logic [RES_W-1:0]  kmask;
  logic [RES_W-1:0]  code_value;
  logic [LEN_W-1:0]  code_length;
  logic [ACC_W:0]    acc_add;
  logic [ACC_W-1:0]  acc_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic              out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      umax_r         <= UMAX_RST;
      dyn_range_r    <= DR_RST;
      rescale_bits_r <= CSZ_RST;
      init_cnt_r     <= INIT_CNT_RST;
      init_acc_r     <= INIT_ACC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UMAX:      umax_r         <= cfg_data[UMAX_W-1:0];
        CFG_DYN_RANGE: dyn_range_r    <= cfg_data[DR_W-1:0];
        CFG_RESCALE:   rescale_bits_r <= cfg_data[CSZ_W-1:0];
        CFG_INIT_CNT:  init_cnt_r     <= cfg_data[CNT_W-1:0];
        CFG_INIT_ACC:  init_acc_r     <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp settings into their legal ranges
  always_comb begin
    d_sat = dyn_range_r;
    if (dyn_range_r < DR_MIN) begin
      d_sat = DR_MIN;
    end else if (dyn_range_r > DR_MAX) begin
      d_sat = DR_MAX;
    end
    um_sat = (umax_r > UMAX_MAX) ? UMAX_MAX : umax_r;
    csz_sat = rescale_bits_r;
    if (rescale_bits_r < CSZ_MIN) begin
      csz_sat = CSZ_MIN;
    end else if (rescale_bits_r > CSZ_MAX) begin
      csz_sat = CSZ_MAX;
    end
  end

  assign k_limit   = K_W'(d_sat - DR_MIN);
  assign dmask     = RES_W'(((RES_W+1)'(1) << d_sat) - (RES_W+1)'(1));
  assign cnt_limit = CNT_W'(((CNT_W+1)'(1) << csz_sat) - (CNT_W+1)'(1));

  // band index folded into the band count, as a constant table
  for (genvar g = 0; g < BAND_LUT_DEPTH; g++) begin : g_band_lut
    assign band_lut[g] = BAND_AW'(g % BAND_COUNT);
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign band_sel      = band_lut[in_chan.band];
  assign m_in          = in_chan.mapped_residual & dmask;

  // band statistics: {counter, accumulator}
  assign rd_cnt = ram_rdata[ACC_W +: CNT_W];
  assign rd_acc = ram_rdata[ACC_W-1:0];

  assign ram_we    = (accept && in_chan.first_in_band) || (state_r == S_CODE);
  assign ram_waddr = (state_r == S_CODE) ? band_r : band_sel;
  assign ram_wdata = (state_r == S_CODE) ? {cnt_upd, acc_upd} : {init_cnt_r, init_acc_r};

  agsc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (BAND_COUNT)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (band_sel),
    .rdata (ram_rdata)
  );

  // k bound: acc + floor(49*cnt/128)
  assign prod49  = PROD_W'(rd_cnt) * PROD_W'(MUL_49);
  assign sum_nxt = SUM_W'(rd_acc) + SUM_W'(prod49 >> FRAC_SHIFT);

  // shared shift-and-compare unit of the k search
  assign cnt_shift = SUM_W'(cnt_r) << (k_r + K_W'(1));
  assign step_ok   = (k_r < k_limit) && (cnt_shift <= sum_r);

  // codeword forming
  assign u_val = m_r >> k_r;
  assign kmask = RES_W'((RES_W'(1) << k_r) - RES_W'(1));
  always_comb begin
    if (u_val < RES_W'(um_sat)) begin
      code_value  = (RES_W'(1) << k_r) | (m_r & kmask);
      code_length = LEN_W'(u_val) + LEN_W'(1) + LEN_W'(k_r);
    end else begin
      code_value  = m_r;
      code_length = LEN_W'(um_sat) + LEN_W'(d_sat);
    end
  end

  // statistics update, halved on rescale
  assign acc_add = (ACC_W+1)'(acc_r) + (ACC_W+1)'(m_r);
  always_comb begin
    if (cnt_r < cnt_limit) begin
      acc_upd = acc_add[ACC_W] ? ACC_MAX : acc_add[ACC_W-1:0];
      cnt_upd = cnt_r + CNT_W'(1);
    end else begin
      acc_upd = ACC_W'((acc_add + (ACC_W+1)'(1)) >> 1);
      cnt_upd = CNT_W'(((CNT_W+1)'(cnt_r) + (CNT_W+1)'(1)) >> 1);
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_chan.first_in_band ? S_OUT : S_LOAD;
        end
      end
      S_LOAD:   state_nxt = S_SEARCH;
      S_SEARCH: begin
        if (!step_ok) begin
          state_nxt = S_CODE;
        end
      end
      S_CODE:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      band_r       <= band_sel;
      m_r          <= m_in;
      res_value_r  <= m_in;
      res_length_r <= LEN_W'(d_sat);
    end
    if (state_r == S_LOAD) begin
      cnt_r <= rd_cnt;
      acc_r <= rd_acc;
      sum_r <= sum_nxt;
      k_r   <= '0;
    end
    if (state_r == S_SEARCH && step_ok) begin
      k_r <= k_r + K_W'(1);
    end
    if (state_r == S_CODE) begin
      res_value_r  <= code_value;
      res_length_r <= code_length;
    end
    if (state_r == S_OUT && out_free) begin
      out_value_r  <= res_value_r;
      out_length_r <= res_length_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.code_value  = out_value_r;
  assign out_chan.code_length = out_length_r;

  // checks
  `AGSC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (state_r == S_IDLE) && !out_valid_r)
  `AGSC_ASSERT_RST(a_k_bound, clk, rst_n, (state_r == S_SEARCH) |-> (k_r <= K_W'(K_MAX)))
  `AGSC_ASSERT_RST(a_coded_reads, clk, rst_n,
    (accept && !in_chan.first_in_band) |=> (state_r == S_LOAD))
  `AGSC_ASSERT_RST(a_first_raw, clk, rst_n,
    (accept && in_chan.first_in_band) |=> (state_r == S_OUT) && (res_length_r == LEN_W'($past(d_sat))))
  `AGSC_ASSERT_RST(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT))
  `AGSC_ASSERT_RST(a_len_range, clk, rst_n,
    out_valid_r |-> (out_length_r != '0) && (out_length_r <= LEN_W'(CODE_LEN_MAX)))

endmodule

### verif/agsc_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsc_code_checker
// Watches the sample and codeword channels and the register port of the
// adaptive Golomb coder. It predicts the codeword of every accepted sample
// from its own copy of the band statistics and the registers, then compares
// each returned codeword, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module agsc_code_checker
  import agsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  agsc_in_if                    sample_mon,
  agsc_out_if                   code_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    codes_pending,
  output int                    codes_checked,
  output int                    escape_count,
  output int                    rescale_count
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic [LEN_W-1:0] length;
  } codeword_t;

  // register shadow
  logic [UMAX_W-1:0] umax_q;
  logic [DR_W-1:0]   depth_q;
  logic [CSZ_W-1:0]  csz_q;
  logic [CNT_W-1:0]  init_cnt_q;
  logic [ACC_W-1:0]  init_acc_q;

  // per-band statistics
  logic [CNT_W-1:0] band_cnt [BAND_LUT_DEPTH];
  logic [ACC_W-1:0] band_acc [BAND_LUT_DEPTH];

  codeword_t code_q [$];
  codeword_t want;

  // codeword of one sample; updates the band statistics
  function automatic codeword_t code_sample(input logic [BAND_W-1:0] band,
                                            input logic first_flag,
                                            input logic [RES_W-1:0] resid);
    codeword_t cw;
    int unsigned depth, ulim, csz, k, limit;
    longint unsigned cnt, acc, bound_sum, m, quot;
    depth = (depth_q < DR_MIN) ? DR_MIN : (depth_q > DR_MAX) ? DR_MAX : depth_q;
    ulim  = (umax_q > UMAX_MAX) ? UMAX_MAX : umax_q;
    csz   = (csz_q < CSZ_MIN) ? CSZ_MIN : (csz_q > CSZ_MAX) ? CSZ_MAX : csz_q;
    m     = resid & ((1 << depth) - 1);
    if (first_flag) begin
      // raw sample, band state loaded from the initial values
      band_cnt[band] = init_cnt_q;
      band_acc[band] = init_acc_q;
      cw.value  = RES_W'(m);
      cw.length = LEN_W'(depth);
    end else begin
      cnt       = band_cnt[band];
      acc       = band_acc[band];
      bound_sum = acc + ((MUL_49 * cnt) >> FRAC_SHIFT);
      // largest k with cnt*2^k <= sum, capped at D-2; zero counter runs to the cap
      k = 0;
      if (2 * cnt <= bound_sum) begin
        while (k < depth - 2 && (cnt << (k + 1)) <= bound_sum) k++;
      end
      quot = m >> k;
      if (quot < ulim) begin
        cw.value  = RES_W'((1 << k) | (m & ((1 << k) - 1)));
        cw.length = LEN_W'(quot + 1 + k);
      end else begin
        // escape: umax zeros then D raw bits
        cw.value  = RES_W'(m);
        cw.length = LEN_W'(ulim + depth);
        escape_count++;
      end
      // statistics update, halved once the counter is at or above its limit
      limit = (1 << csz) - 1;
      if (cnt < limit) begin
        acc = acc + m;
        if (acc > ACC_MAX) acc = ACC_MAX;
        cnt = cnt + 1;
      end else begin
        acc = (acc + m + 1) >> 1;
        cnt = (cnt + 1) >> 1;
        rescale_count++;
      end
      band_cnt[band] = CNT_W'(cnt);
      band_acc[band] = ACC_W'(acc);
    end
    return cw;
  endfunction

  // predict on sample items, compare on codeword items, track registers
  always @(posedge clk) begin
    if (!rst_n) begin
      umax_q         = UMAX_RST;
      depth_q        = DR_RST;
      csz_q          = CSZ_RST;
      init_cnt_q     = INIT_CNT_RST;
      init_acc_q     = INIT_ACC_RST;
      code_q.delete();
      mismatch_count = 0;
      codes_pending  = 0;
      codes_checked  = 0;
      escape_count   = 0;
      rescale_count  = 0;
    end else begin
      if (sample_mon.valid && sample_mon.ready) begin
        code_q.push_back(code_sample(sample_mon.band, sample_mon.first_in_band,
                                     sample_mon.mapped_residual));
      end
      if (code_mon.valid && code_mon.ready) begin
        codes_checked++;
        if (code_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: codeword value %h length %0d with no sample pending",
                     $time, code_mon.code_value, code_mon.code_length);
        end else begin
          want = code_q.pop_front();
          if (code_mon.code_value !== want.value || code_mon.code_length !== want.length) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: codeword %0d expected value %h length %0d, got value %h length %0d",
                       $time, codes_checked, want.value, want.length,
                       code_mon.code_value, code_mon.code_length);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_UMAX:      umax_q     = cfg_data[UMAX_W-1:0];
          CFG_DYN_RANGE: depth_q    = cfg_data[DR_W-1:0];
          CFG_RESCALE:   csz_q      = cfg_data[CSZ_W-1:0];
          CFG_INIT_CNT:  init_cnt_q = cfg_data[CNT_W-1:0];
          CFG_INIT_ACC:  init_acc_q = cfg_data[ACC_W-1:0];
          default: ;
        endcase
      end
      codes_pending = code_q.size();
    end
  end

endmodule

### verif/tb_adaptive_golomb_sample_coder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_golomb_sample_coder_top
// Drives the adaptive Golomb coder with a short directed sample list and
// then random per-band sample streams under several register settings,
// including out-of-range values. Both channels idle at random. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_adaptive_golomb_sample_coder_top;
  import agsc_pkg::*;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 165;
  localparam int HOT_BANDS   = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  agsc_in_if  sample_ch ();
  agsc_out_if code_ch ();

  int mismatch_count, codes_pending, codes_checked, escape_count, rescale_count;
  int quiet_cycles = 0;
  int samples_sent;
  bit sender_steady, receiver_steady;
  bit band_live [BAND_LUT_DEPTH];
  logic [BAND_W-1:0] hot_band [HOT_BANDS];

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  adaptive_golomb_sample_coder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (sample_ch),
    .out_chan  (code_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  agsc_code_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_mon     (sample_ch),
    .code_mon       (code_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .codes_pending  (codes_pending),
    .codes_checked  (codes_checked),
    .escape_count   (escape_count),
    .rescale_count  (rescale_count)
  );

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [RES_W-1:0] pick_residual();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return RES_W'($urandom_range(0, 15));
      4, 5, 6:    return RES_W'($urandom);
      7:          return RES_W'($urandom_range(0, 255));
      8:          return '1;
      default:    return '0;
    endcase
  endfunction

  // one sample item, after an optional idle gap
  task automatic send_sample(input logic [BAND_W-1:0] band, input logic first_flag,
                             input logic [RES_W-1:0] resid);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid = 1'b0;
    end
    @(negedge clk);
    sample_ch.valid           = 1'b1;
    sample_ch.band            = band;
    sample_ch.first_in_band   = first_flag;
    sample_ch.mapped_residual = resid;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (first_flag) band_live[band] = 1'b1;
    samples_sent++;
  endtask

  // stop sending and wait for every codeword to come back
  task automatic drain();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (codes_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(data);
  endtask

  task automatic apply_setting(input int unsigned ulim, input int unsigned depth,
                               input int unsigned csz, input int unsigned icnt,
                               input int unsigned iacc);
    write_reg(CFG_UMAX, ulim);
    write_reg(CFG_DYN_RANGE, depth);
    write_reg(CFG_RESCALE, csz);
    write_reg(CFG_INIT_CNT, icnt);
    write_reg(CFG_INIT_ACC, iacc);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // receiver: random stalls, none while steady
  initial begin
    int stall_left;
    stall_left    = 0;
    code_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_steady) begin
        code_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        code_ch.ready = 1'b0;
        stall_left--;
      end else begin
        code_ch.ready = 1'b1;
        stall_left    = pick_gap();
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (sample_ch.valid && sample_ch.ready) || (code_ch.valid && code_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int blk;
    logic [BAND_W-1:0] b;
    logic f;
    rst_n                     = 1'b0;
    sample_ch.valid           = 1'b0;
    sample_ch.band            = '0;
    sample_ch.first_in_band   = 1'b0;
    sample_ch.mapped_residual = '0;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_UMAX;
    cfg_data                  = '0;
    sender_steady             = 1'b0;
    receiver_steady           = 1'b0;
    samples_sent              = 0;
    foreach (band_live[i]) band_live[i] = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings: band extremes, escapes, unary limit edge, re-init
    send_sample(8'd0,   1'b1, 16'h0000);
    send_sample(8'd255, 1'b1, 16'hFFFF);
    send_sample(8'd128, 1'b1, 16'h5A5A);
    send_sample(8'd0,   1'b0, 16'h0000);
    send_sample(8'd0,   1'b0, 16'hFFFF);
    send_sample(8'd255, 1'b0, 16'h0001);
    send_sample(8'd255, 1'b0, 16'h00FF);
    send_sample(8'd128, 1'b0, 16'h7FFF);
    send_sample(8'd128, 1'b0, 16'h8000);
    // re-init band 0, then unary length just under and at the limit
    send_sample(8'd0,   1'b1, 16'h0003);
    send_sample(8'd0,   1'b0, 16'h0225);
    send_sample(8'd0,   1'b0, 16'h0900);
    send_sample(8'd127, 1'b1, 16'hAAAA);
    send_sample(8'd127, 1'b0, 16'h5555);
    send_sample(8'd127, 1'b0, 16'h0000);
    send_sample(8'd255, 1'b0, 16'hFFFE);

    // random per-band streams under each register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      case (p)
        0: apply_setting(18, 16, 8, 2, 95);
        1: apply_setting(0, 16, 4, 1, 0);
        2: apply_setting(63, 2, 15, 2047, ACC_MAX);
        3: apply_setting(32, 0, 0, 0, 0);
        4: begin
          write_reg(CFG_SPARE, $urandom);
          apply_setting(8, 8, 11, 100, ACC_MAX);
        end
        5: apply_setting(12, 31, 6, 5, 1000);
        6: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
        default: apply_setting(20, 12, 7, 3, 300);
      endcase
      foreach (hot_band[h]) hot_band[h] = BAND_W'($urandom_range(0, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        blk             = n / 40;
        sender_steady   = (blk % 3 == 2);
        receiver_steady = (blk % 3 != 0) && (p % 2 == 1);
        // most samples hit a few bands so counters reach their rescale point
        b = ($urandom_range(0, 9) < 7) ? hot_band[$urandom_range(0, HOT_BANDS - 1)]
                                       : BAND_W'($urandom_range(0, 255));
        f = !band_live[b] || ($urandom_range(0, 14) == 0);
        send_sample(b, f, pick_residual());
      end
    end

    drain();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d samples over %0d register settings, %0d codewords checked",
             samples_sent, PHASE_COUNT + 1, codes_checked);
    $display("Seen %0d escape codes and %0d counter rescales, %0d mismatches",
             escape_count, rescale_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
